@@ src/slin_pkg.sv @@
`default_nettype none

package slin_pkg;

    localparam int TABLE_ENTRIES = 33;

    localparam int SAMPLE_W    = 16;
    localparam int ENTRY_W     = 16;
    localparam int ENTRY_IDX_W = 6;
    localparam int OUT_W       = 48;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;

    localparam int TBL_AW = $clog2(TABLE_ENTRIES);
    localparam int IDX_W  = ((TBL_AW > ENTRY_IDX_W) ? TBL_AW : ENTRY_IDX_W) + 1;

    localparam int FRAC_W    = 16;
    localparam int REM_W     = 10;
    localparam int SEG_W     = SAMPLE_W - 1 - REM_W;
    localparam int INTERP_SH = FRAC_W - REM_W;
    localparam int DIFF_W    = ENTRY_W + 1;

    // radix-4 shift-add multiplier
    localparam int MCAND_W   = 32;
    localparam int MPLR_W    = 34;
    localparam int HI_W      = MCAND_W + 3;
    localparam int PROD_W    = HI_W + MPLR_W;
    localparam int MUL_STEPS = MPLR_W / 2;
    localparam int STEP_W    = $clog2(MUL_STEPS);

    localparam int RND_W = PROD_W - FRAC_W;
    localparam int R_W   = RND_W + 1;

    localparam logic signed [MCAND_W-1:0] LIN_COEF   = 32'sd332267;
    localparam logic signed [MCAND_W-1:0] RES_COEF   = 32'sd507000;
    localparam logic signed [CFG_W-1:0]   GAIN_RESET = 32'sd65536;
    localparam logic [PROD_W-1:0]         ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_WRITE   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

    typedef enum logic [1:0] {
        MODE_HOLD   = 2'd0,
        MODE_LINEAR = 2'd1,
        MODE_TABLE  = 2'd2,
        MODE_SCALE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_LO,
        ST_RD_HI,
        ST_MUL,
        ST_ROUND,
        ST_FIN,
        ST_SAT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                       start;
        logic signed [MCAND_W-1:0]  mcand;
        logic        [MPLR_W-1:0]   operand;
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic last_step;
    } mul_stat_t;

endpackage

`default_nettype wire

@@ src/slin_mul.sv @@
`default_nettype none

module slin_mul import slin_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire mul_req_t                  req,
    output mul_stat_t                      stat,
    output logic signed [PROD_W-1:0]       prod
);

    logic                      busy_reg;
    logic [STEP_W-1:0]         cnt_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [MCAND_W-1:0] m1_reg;
    logic signed [HI_W-1:0]    m3_reg;

    logic signed [HI_W-1:0]    hi;
    logic signed [HI_W-1:0]    m1x;
    logic signed [HI_W-1:0]    m2x;
    logic signed [HI_W-1:0]    addend;
    logic signed [HI_W-1:0]    sum;
    logic signed [HI_W-1:0]    mcand_x;
    logic [1:0]                dig;
    logic                      last;

    assign hi      = prod_reg[PROD_W-1 -: HI_W];
    assign dig     = prod_reg[1:0];
    assign last    = (cnt_reg == '0);
    assign m1x     = HI_W'(m1_reg);
    assign m2x     = m1x <<< 1;
    assign mcand_x = HI_W'(req.mcand);

    // top digit of the multiplier carries negative weight
    always_comb
    begin
        if (!last)
        begin
            case (dig)
                2'd0:    addend = '0;
                2'd1:    addend = m1x;
                2'd2:    addend = m2x;
                default: addend = m3_reg;
            endcase
        end
        else
        begin
            case (dig)
                2'd0:    addend = '0;
                2'd1:    addend = m1x;
                2'd2:    addend = -m2x;
                default: addend = -m1x;
            endcase
        end
    end

    assign sum = hi + addend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= STEP_W'(MUL_STEPS - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg <= {{HI_W{1'b0}}, req.operand};
            m1_reg   <= req.mcand;
            m3_reg   <= mcand_x + (mcand_x <<< 1);
        end
        else if (busy_reg)
        begin
            prod_reg <= {{2{sum[HI_W-1]}}, sum, prod_reg[MPLR_W-1:2]};
        end
    end

    assign stat.busy      = busy_reg;
    assign stat.last_step = busy_reg && last;
    assign prod           = prod_reg;

endmodule

`default_nettype wire

@@ src/sensor_lut_linearizer.sv @@
// sensor_lut_linearizer: converts 16-bit converter samples to signed Q32.16 values
// input channel (in_valid/in_ready): opcode 0 converts sample, opcode 1 writes
//   entry_value into table position entry_index (positions past the table are dropped)
// output channel (out_valid/out_ready): result_value and saturated, one transaction
//   per conversion, none per table write
// config channel (cfg_valid/cfg_ready, always ready): index 0 mode, 1 gain, 2 offset
// one item is worked at a time; the arithmetic runs through a radix-4 shift-add
//   multiplier, 2 multiplier bits per cycle
// in_ready returns in the same cycle as out_valid; a table write leaves the block
//   idle, ready for the next item
// the output register lets the next item be taken while a result waits; if the
//   receiver stalls, the following result waits in the block and in_ready stays low
// reset empties the table (all entries read as zero), clears the held value to zero, sets mode to hold,
//   gain to 1.0 and offset to 0; the block is ready the first cycle after reset
`default_nettype none

module sensor_lut_linearizer import slin_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        opcode,
    input  wire logic [SAMPLE_W-1:0]         sample,
    input  wire logic [ENTRY_IDX_W-1:0]      entry_index,
    input  wire logic signed [ENTRY_W-1:0]   entry_value,

    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [OUT_W-1:0]          result_value,
    output logic                             saturated,

    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]            cfg_data
);

    state_t                     state_reg;
    state_t                     state_next;

    mode_t                      mode_reg;
    logic signed [CFG_W-1:0]    gain_reg;
    logic signed [CFG_W-1:0]    offset_reg;

    logic signed [ENTRY_W-1:0]  curve_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]   entry_vld_reg;
    logic signed [ENTRY_W-1:0]  rd_data_reg;
    logic                       rd_vld_reg;

    logic [SAMPLE_W-1:0]        sample_reg;
    logic signed [ENTRY_W-1:0]  a_reg;
    logic signed [RND_W-1:0]    rnd_reg;
    logic signed [R_W-1:0]      r_reg;
    logic                       second_reg;
    logic signed [OUT_W-1:0]    res_reg;
    logic                       sat_reg;
    logic signed [OUT_W-1:0]    last_value_reg;
    logic                       out_valid_reg;
    logic signed [OUT_W-1:0]    out_value_reg;
    logic                       out_sat_reg;

    mul_req_t                   mul_req;
    mul_stat_t                  mul_stat;
    logic signed [PROD_W-1:0]   prod;

    logic                       in_acc;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_idx;
    logic [IDX_W-1:0]           seg_idx;
    logic [IDX_W-1:0]           lo_idx;
    logic [IDX_W-1:0]           rd_idx;
    logic                       beyond;
    logic [SAMPLE_W-1:0]        smp;
    logic [REM_W-1:0]           rem;
    logic signed [ENTRY_W-1:0]  rd_entry;
    logic signed [DIFF_W-1:0]   diff;
    logic [MPLR_W-1:0]          v_beyond;
    logic [MPLR_W-1:0]          v_interp;
    logic signed [CFG_W:0]      d_lin;
    logic [PROD_W-1:0]          rsum;
    logic                       start_second;
    logic signed [R_W-1:0]      r_calc;
    logic [R_W-OUT_W:0]         r_top;
    logic                       ovf;
    logic                       out_load;

    slin_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .stat  (mul_stat),
        .prod  (prod)
    );

    assign in_acc = in_valid && in_ready;
    assign wr_idx = IDX_W'(entry_index);
    assign wr_en  = in_acc && (opcode == OP_WRITE) && (wr_idx < IDX_W'(TABLE_ENTRIES));

    // segment and remainder of the halved sample
    assign smp     = (state_reg == ST_IDLE) ? sample : sample_reg;
    assign rem     = smp[REM_W:1];
    assign seg_idx = IDX_W'(smp[SAMPLE_W-1 -: SEG_W]);
    assign beyond  = (seg_idx + 1'b1) >= IDX_W'(TABLE_ENTRIES);
    assign lo_idx  = beyond ? IDX_W'(TABLE_ENTRIES - 1) : seg_idx;
    assign rd_idx  = (state_reg == ST_RD_LO) ? (seg_idx + 1'b1) : lo_idx;

    assign rd_entry = rd_vld_reg ? rd_data_reg : '0;
    assign diff     = DIFF_W'(rd_entry) - DIFF_W'(a_reg);
    assign v_beyond = MPLR_W'(rd_entry) << FRAC_W;
    assign v_interp = (MPLR_W'(a_reg) << FRAC_W) + (prod[MPLR_W-1:0] << INTERP_SH);
    assign d_lin    = (CFG_W + 1)'(rnd_reg) - (CFG_W + 1)'(offset_reg);
    assign rsum     = prod + ROUND_HALF;

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // table memory with per-entry valid bits
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            curve_mem[wr_idx[TBL_AW-1:0]] <= entry_value;
        end
        rd_data_reg <= curve_mem[rd_idx[TBL_AW-1:0]];
        rd_vld_reg  <= entry_vld_reg[rd_idx[TBL_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_vld_reg <= '0;
        end
        else if (wr_en)
        begin
            entry_vld_reg[wr_idx[TBL_AW-1:0]] <= 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_HOLD;
            gain_reg   <= GAIN_RESET;
            offset_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= mode_t'(cfg_data[1:0]);
                CFG_GAIN:   gain_reg   <= cfg_data;
                CFG_OFFSET: offset_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        mul_req.start   = 1'b0;
        mul_req.mcand   = gain_reg;
        mul_req.operand = '0;
        start_second    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (opcode == OP_CONVERT))
                begin
                    case (mode_reg)
                        MODE_HOLD:
                        begin
                            state_next = ST_DONE;
                        end
                        MODE_TABLE:
                        begin
                            state_next = ST_RD_LO;
                        end
                        MODE_LINEAR:
                        begin
                            mul_req.start   = 1'b1;
                            mul_req.mcand   = LIN_COEF;
                            mul_req.operand = MPLR_W'(sample);
                            state_next      = ST_MUL;
                        end
                        default:
                        begin
                            mul_req.start   = 1'b1;
                            mul_req.mcand   = RES_COEF;
                            mul_req.operand = MPLR_W'(sample);
                            state_next      = ST_MUL;
                        end
                    endcase
                end
            end
            ST_RD_LO:
            begin
                if (beyond)
                begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = v_beyond;
                    start_second    = 1'b1;
                    state_next      = ST_MUL;
                end
                else
                begin
                    state_next = ST_RD_HI;
                end
            end
            ST_RD_HI:
            begin
                mul_req.start   = 1'b1;
                mul_req.mcand   = MCAND_W'(diff);
                mul_req.operand = MPLR_W'(rem);
                state_next      = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_stat.last_step)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!second_reg && (mode_reg != MODE_SCALE))
                begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = (mode_reg == MODE_TABLE) ? v_interp : MPLR_W'(d_lin);
                    start_second    = 1'b1;
                    state_next      = ST_MUL;
                end
                else
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // final value before clipping
    always_comb
    begin
        case (mode_reg)
            MODE_SCALE:  r_calc = R_W'(prod);
            MODE_LINEAR: r_calc = R_W'(rnd_reg);
            default:     r_calc = R_W'(rnd_reg) - R_W'(offset_reg);
        endcase
    end

    assign r_top = r_reg[R_W-1:OUT_W-1];
    assign ovf   = !((&r_top) || !(|r_top));

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            sample_reg <= sample;
        end
        if (mul_req.start)
        begin
            second_reg <= start_second;
        end
        if (state_reg == ST_RD_LO)
        begin
            a_reg <= rd_entry;
        end
        if (state_reg == ST_ROUND)
        begin
            rnd_reg <= rsum[PROD_W-1:FRAC_W];
        end
        if (state_reg == ST_FIN)
        begin
            r_reg <= r_calc;
        end
        if (in_acc && (opcode == OP_CONVERT) && (mode_reg == MODE_HOLD))
        begin
            res_reg <= last_value_reg;
            sat_reg <= 1'b0;
        end
        else if (state_reg == ST_SAT)
        begin
            res_reg <= ovf ? (r_reg[R_W-1] ? OUT_MIN : OUT_MAX) : r_reg[OUT_W-1:0];
            sat_reg <= ovf;
        end
        if (out_load)
        begin
            out_value_reg <= res_reg;
            out_sat_reg   <= sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_value_reg <= '0;
        end
        else if (state_reg == ST_SAT)
        begin
            last_value_reg <= ovf ? (r_reg[R_W-1] ? OUT_MIN : OUT_MAX) : r_reg[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign saturated    = out_sat_reg;

    // multiplier runs only while the sequencer waits on it
    a_mul_owned: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.busy |-> (state_reg == ST_MUL))
        else $error("multiplier busy outside multiply state");

    // clipped results sit on a range bound
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> ((result_value == OUT_MAX) || (result_value == OUT_MIN)))
        else $error("saturated result not at a bound");

    // a finished result reaches the output register when the slot is free
    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && (!out_valid_reg || out_ready))
        |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("result not handed to output register");

endmodule

`default_nettype wire
